FILE: design/mp3_frame_header_decoder_defines.svh
// Assertion macros used by the frame header decoder top level
`ifndef MP3_FRAME_HEADER_DECODER_DEFINES_SVH
`define MP3_FRAME_HEADER_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define MFHD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mfhd assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define MFHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mfhd assertion failed");

`endif

FILE: design/mfhd_pkg.sv
// Types, constants and lookup tables of the MPEG audio frame header decoder
package mfhd_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [15:0] AVAIL_MASK = (COUNT_BITS >= 16) ? 16'hFFFF :
                                         16'((32'd1 << COUNT_BITS) - 32'd1);

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_NEED_DATA   = 2'd3;

    localparam logic [1:0] VER_25   = 2'd0;
    localparam logic [1:0] VER_RSVD = 2'd1;
    localparam logic [1:0] VER_2    = 2'd2;
    localparam logic [1:0] VER_1    = 2'd3;

    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] LAYER_3    = 2'd1;

    localparam logic [31:0] SYNC_MASK  = 32'hFFE0_0000;
    localparam logic [3:0]  BIDX_FREE  = 4'd0;
    localparam logic [3:0]  BIDX_BAD   = 4'd15;
    localparam logic [1:0]  SIDX_RSVD  = 2'd3;
    localparam logic [1:0]  EMPH_RSVD  = 2'd2;
    localparam logic [1:0]  CMODE_MONO = 2'd3;
    localparam logic [15:0] MIN_AVAIL  = 16'd4;

    localparam logic [17:0] K_V1 = 18'd144000;
    localparam logic [17:0] K_V2 = 18'd72000;

    localparam int PROD_BITS   = 26;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_BITS  = 14;
    localparam int FSIZE_BITS  = 11;
    localparam int BACK_BITS   = 27;
    localparam int EST_BITS    = PROD_BITS + RECIP_BITS;

    localparam int RECIP_44100 = (1 << RECIP_SHIFT) / 44100;
    localparam int RECIP_48000 = (1 << RECIP_SHIFT) / 48000;
    localparam int RECIP_32000 = (1 << RECIP_SHIFT) / 32000;
    localparam int RECIP_22050 = (1 << RECIP_SHIFT) / 22050;
    localparam int RECIP_24000 = (1 << RECIP_SHIFT) / 24000;
    localparam int RECIP_16000 = (1 << RECIP_SHIFT) / 16000;
    localparam int RECIP_11025 = (1 << RECIP_SHIFT) / 11025;
    localparam int RECIP_12000 = (1 << RECIP_SHIFT) / 12000;
    localparam int RECIP_8000  = (1 << RECIP_SHIFT) / 8000;

    typedef struct packed {
        logic [31:0] hdr_word;
        logic [15:0] bytes_available;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  version;
        logic [8:0]  kbit_rate;
        logic [15:0] samp_hz;
        logic [1:0]  chan_mode;
        logic [1:0]  mode_ext;
        logic [1:0]  emphasis;
        logic [4:0]  flags;
        logic [10:0] frame_len;
        logic [10:0] frame_samples;
        logic [2:0]  hdr_size;
        logic [5:0]  side_size;
    } t_out_beat;

    typedef struct packed {
        logic                  early;
        logic [1:0]            early_status;
        logic                  is_v1;
        logic [RECIP_BITS-1:0] recip;
        logic [15:0]           avail;
        t_out_beat             fields;
    } t_dec;

    function automatic logic [8:0] kbps_v1(input logic [3:0] bidx);
        logic [8:0] v;
        case (bidx)
            4'd1:    v = 9'd32;
            4'd2:    v = 9'd40;
            4'd3:    v = 9'd48;
            4'd4:    v = 9'd56;
            4'd5:    v = 9'd64;
            4'd6:    v = 9'd80;
            4'd7:    v = 9'd96;
            4'd8:    v = 9'd112;
            4'd9:    v = 9'd128;
            4'd10:   v = 9'd160;
            4'd11:   v = 9'd192;
            4'd12:   v = 9'd224;
            4'd13:   v = 9'd256;
            4'd14:   v = 9'd320;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] kbps_v2(input logic [3:0] bidx);
        logic [8:0] v;
        case (bidx)
            4'd1:    v = 9'd8;
            4'd2:    v = 9'd16;
            4'd3:    v = 9'd24;
            4'd4:    v = 9'd32;
            4'd5:    v = 9'd40;
            4'd6:    v = 9'd48;
            4'd7:    v = 9'd56;
            4'd8:    v = 9'd64;
            4'd9:    v = 9'd80;
            4'd10:   v = 9'd96;
            4'd11:   v = 9'd112;
            4'd12:   v = 9'd128;
            4'd13:   v = 9'd144;
            4'd14:   v = 9'd160;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sample_rate(input logic [1:0] ver, input logic [1:0] sidx);
        logic [15:0] v;
        case ({ver, sidx})
            {VER_1, 2'd0}:  v = 16'd44100;
            {VER_1, 2'd1}:  v = 16'd48000;
            {VER_1, 2'd2}:  v = 16'd32000;
            {VER_2, 2'd0}:  v = 16'd22050;
            {VER_2, 2'd1}:  v = 16'd24000;
            {VER_2, 2'd2}:  v = 16'd16000;
            {VER_25, 2'd0}: v = 16'd11025;
            {VER_25, 2'd1}: v = 16'd12000;
            {VER_25, 2'd2}: v = 16'd8000;
            default:        v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [RECIP_BITS-1:0] recip(input logic [1:0] ver,
                                                    input logic [1:0] sidx);
        logic [RECIP_BITS-1:0] v;
        case ({ver, sidx})
            {VER_1, 2'd0}:  v = RECIP_BITS'(RECIP_44100);
            {VER_1, 2'd1}:  v = RECIP_BITS'(RECIP_48000);
            {VER_1, 2'd2}:  v = RECIP_BITS'(RECIP_32000);
            {VER_2, 2'd0}:  v = RECIP_BITS'(RECIP_22050);
            {VER_2, 2'd1}:  v = RECIP_BITS'(RECIP_24000);
            {VER_2, 2'd2}:  v = RECIP_BITS'(RECIP_16000);
            {VER_25, 2'd0}: v = RECIP_BITS'(RECIP_11025);
            {VER_25, 2'd1}: v = RECIP_BITS'(RECIP_12000);
            {VER_25, 2'd2}: v = RECIP_BITS'(RECIP_8000);
            default:        v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/mp3_frame_header_decoder.sv
// Top level of the MPEG audio Layer III frame header decoder
// Pipeline: six register stages from input beat to output beat.
// Throughput: one header word per cycle; the whole pipe holds while an output beat waits.
// Frame length uses a reciprocal multiply, a back-multiply and a remainder correction.
// Reset: synchronous, active low; clears the stage valid bits only.
`include "mp3_frame_header_decoder_defines.svh"

module mp3_frame_header_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mfhd_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mfhd_pkg::t_out_beat o_out
);

    logic                en;
    logic                w_p_valid;
    mfhd_pkg::t_dec      w_p_dec;
    logic                w_s_valid;
    mfhd_pkg::t_dec      w_s_dec;

    logic                r_out_valid;
    mfhd_pkg::t_out_beat r_out;
    mfhd_pkg::t_out_beat n_out;
    logic [10:0]         min_size;

    assign en = !r_out_valid || i_out_ready;

    mfhd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_in    (i_in),
        .o_valid (w_p_valid),
        .o_dec   (w_p_dec)
    );

    mfhd_size u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_p_valid),
        .i_dec   (w_p_dec),
        .o_valid (w_s_valid),
        .o_dec   (w_s_dec)
    );

    always_comb begin
        min_size = 11'(w_s_dec.fields.hdr_size) + 11'(w_s_dec.fields.side_size);
        if (w_s_dec.early) begin
            n_out        = '0;
            n_out.status = w_s_dec.early_status;
        end else if (w_s_dec.fields.frame_len < min_size) begin
            n_out        = '0;
            n_out.status = mfhd_pkg::ST_INVALID;
        end else begin
            n_out        = w_s_dec.fields;
            n_out.status = (w_s_dec.avail < 16'(w_s_dec.fields.frame_len)) ?
                           mfhd_pkg::ST_NEED_DATA : mfhd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `MFHD_ASSERT_NEXT(a_accept_enters_pipe, i_in_valid && o_in_ready, w_p_valid)
    `MFHD_ASSERT_NEXT(a_stall_holds_item, w_s_valid && !en, w_s_valid)
    `MFHD_ASSERT_IMP(a_ok_fields_sane, o_out_valid && (o_out.status == mfhd_pkg::ST_OK), (o_out.kbit_rate != 9'd0) && (o_out.samp_hz != 16'd0) && (o_out.frame_len >= 11'(o_out.hdr_size) + 11'(o_out.side_size)))
    `MFHD_ASSERT_IMP(a_reject_clears_fields, o_out_valid && ((o_out.status == mfhd_pkg::ST_INVALID) || (o_out.status == mfhd_pkg::ST_UNSUPPORTED)), (o_out.frame_len == 11'd0) && (o_out.frame_samples == 11'd0))

endmodule

FILE: design/mfhd_parse.sv
// Stage one: field split, header checks and table lookups
module mfhd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  mfhd_pkg::t_in_beat i_in,
    output logic              o_valid,
    output mfhd_pkg::t_dec    o_dec
);

    logic           r_valid;
    mfhd_pkg::t_dec r_dec;
    mfhd_pkg::t_dec n_dec;

    logic [31:0] w;
    logic [15:0] avail;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic        prot;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    logic [1:0]  cmode;
    logic [1:0]  emph;
    logic        is_v1;

    always_comb begin
        w     = i_in.hdr_word;
        avail = i_in.bytes_available & mfhd_pkg::AVAIL_MASK;
        ver   = w[20:19];
        lay   = w[18:17];
        prot  = w[16];
        bidx  = w[15:12];
        sidx  = w[11:10];
        cmode = w[7:6];
        emph  = w[1:0];
        is_v1 = (ver == mfhd_pkg::VER_1);

        n_dec                      = '0;
        n_dec.is_v1                = is_v1;
        n_dec.recip                = mfhd_pkg::recip(ver, sidx);
        n_dec.avail                = avail;
        n_dec.fields.status        = mfhd_pkg::ST_OK;
        n_dec.fields.version       = ver;
        n_dec.fields.kbit_rate     = is_v1 ? mfhd_pkg::kbps_v1(bidx) :
                                             mfhd_pkg::kbps_v2(bidx);
        n_dec.fields.samp_hz       = mfhd_pkg::sample_rate(ver, sidx);
        n_dec.fields.chan_mode     = cmode;
        n_dec.fields.mode_ext      = w[5:4];
        n_dec.fields.emphasis      = emph;
        n_dec.fields.flags         = {w[2], w[3], w[8], w[9], ~prot};
        n_dec.fields.frame_len     = '0;
        n_dec.fields.frame_samples = is_v1 ? 11'd1152 : 11'd576;
        n_dec.fields.hdr_size      = prot ? 3'd4 : 3'd6;
        if (cmode == mfhd_pkg::CMODE_MONO) begin
            n_dec.fields.side_size = is_v1 ? 6'd17 : 6'd9;
        end else begin
            n_dec.fields.side_size = is_v1 ? 6'd32 : 6'd17;
        end

        n_dec.early = 1'b1;
        if (avail < mfhd_pkg::MIN_AVAIL) begin
            n_dec.early_status = mfhd_pkg::ST_NEED_DATA;
        end else if ((w & mfhd_pkg::SYNC_MASK) != mfhd_pkg::SYNC_MASK) begin
            n_dec.early_status = mfhd_pkg::ST_INVALID;
        end else if (ver == mfhd_pkg::VER_RSVD) begin
            n_dec.early_status = mfhd_pkg::ST_INVALID;
        end else if (lay == mfhd_pkg::LAYER_RSVD) begin
            n_dec.early_status = mfhd_pkg::ST_INVALID;
        end else if (lay != mfhd_pkg::LAYER_3) begin
            n_dec.early_status = mfhd_pkg::ST_UNSUPPORTED;
        end else if (bidx == mfhd_pkg::BIDX_BAD) begin
            n_dec.early_status = mfhd_pkg::ST_INVALID;
        end else if (bidx == mfhd_pkg::BIDX_FREE) begin
            n_dec.early_status = mfhd_pkg::ST_UNSUPPORTED;
        end else if (sidx == mfhd_pkg::SIDX_RSVD) begin
            n_dec.early_status = mfhd_pkg::ST_INVALID;
        end else if (emph == mfhd_pkg::EMPH_RSVD) begin
            n_dec.early_status = mfhd_pkg::ST_INVALID;
        end else begin
            n_dec.early        = 1'b0;
            n_dec.early_status = mfhd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

FILE: design/mfhd_size.sv
// Stages two to five: frame length by reciprocal multiply and remainder correction
module mfhd_size (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  mfhd_pkg::t_dec i_dec,
    output logic           o_valid,
    output mfhd_pkg::t_dec o_dec
);

    logic [3:0] r_valid;

    mfhd_pkg::t_dec r_dec2;
    mfhd_pkg::t_dec r_dec3;
    mfhd_pkg::t_dec r_dec4;
    mfhd_pkg::t_dec r_dec5;
    mfhd_pkg::t_dec n_dec5;

    logic [mfhd_pkg::PROD_BITS-1:0]  r_prod2;
    logic [mfhd_pkg::PROD_BITS-1:0]  r_prod3;
    logic [mfhd_pkg::PROD_BITS-1:0]  r_prod4;
    logic [mfhd_pkg::FSIZE_BITS-1:0] r_est3;
    logic [mfhd_pkg::FSIZE_BITS-1:0] r_est4;
    logic [mfhd_pkg::BACK_BITS-1:0]  r_back4;

    logic [mfhd_pkg::PROD_BITS-1:0]  n_prod;
    logic [mfhd_pkg::PROD_BITS-1:0]  k_ext;
    logic [mfhd_pkg::PROD_BITS-1:0]  kbps_ext;
    logic [mfhd_pkg::EST_BITS-1:0]   est_full;
    logic [mfhd_pkg::FSIZE_BITS-1:0] n_est;
    logic [mfhd_pkg::BACK_BITS-1:0]  n_back;
    logic [mfhd_pkg::BACK_BITS-1:0]  rem;
    logic                            corr;
    logic [mfhd_pkg::FSIZE_BITS-1:0] n_fsize;

    always_comb begin
        k_ext    = i_dec.is_v1 ? mfhd_pkg::PROD_BITS'(mfhd_pkg::K_V1) :
                                 mfhd_pkg::PROD_BITS'(mfhd_pkg::K_V2);
        kbps_ext = mfhd_pkg::PROD_BITS'(i_dec.fields.kbit_rate);
        n_prod   = k_ext * kbps_ext;

        est_full = mfhd_pkg::EST_BITS'(r_prod2) * mfhd_pkg::EST_BITS'(r_dec2.recip);
        n_est    = est_full[mfhd_pkg::RECIP_SHIFT+mfhd_pkg::FSIZE_BITS-1:mfhd_pkg::RECIP_SHIFT];

        n_back   = mfhd_pkg::BACK_BITS'(r_est3) *
                   mfhd_pkg::BACK_BITS'(r_dec3.fields.samp_hz);

        rem      = mfhd_pkg::BACK_BITS'(r_prod4) - r_back4;
        corr     = (rem >= mfhd_pkg::BACK_BITS'(r_dec4.fields.samp_hz));
        n_fsize  = r_est4 + mfhd_pkg::FSIZE_BITS'(corr) +
                   mfhd_pkg::FSIZE_BITS'(r_dec4.fields.flags[1]);

        n_dec5                  = r_dec4;
        n_dec5.fields.frame_len = n_fsize;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec2  <= i_dec;
            r_prod2 <= n_prod;
            r_dec3  <= r_dec2;
            r_prod3 <= r_prod2;
            r_est3  <= n_est;
            r_dec4  <= r_dec3;
            r_prod4 <= r_prod3;
            r_est4  <= r_est3;
            r_back4 <= n_back;
            r_dec5  <= n_dec5;
        end
    end

    assign o_valid = r_valid[3];
    assign o_dec   = r_dec5;

endmodule
